// ===== rtl/wpws_pkg.sv =====
package wpws_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int THREAD_W    = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SYM_W       = 8;
    localparam int COUNT_W     = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FEED = 1'b1;

    localparam logic [SYM_W-1:0] SYM_ANY_ONE     = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_ZERO_OR_ONE = 8'h2D;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] WINDOW_RESET = 16'hFFFF;

    typedef logic [PATTERN_MAX-1:0][SYM_W-1:0] sym_array_t;

    // Decoded view of the loaded pattern, handed to the match step
    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic [PATTERN_MAX-1:0] opt;
        logic [PATTERN_MAX-1:0] wild;
        sym_array_t             syms;
    } pattern_view_t;

    // One accepted sequence byte, as seen by the match step
    typedef struct packed {
        logic             start;
        logic [SYM_W-1:0] symbol;
    } step_in_t;

endpackage

// ===== rtl/wpws_in_if.sv =====
interface wpws_in_if import wpws_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output opcode, output symbol, output last, input ready);
    modport sink   (input valid, input opcode, input symbol, input last, output ready);
endinterface

// ===== rtl/wpws_out_if.sv =====
interface wpws_out_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

// ===== rtl/wpws_pattern.sv =====
module wpws_pattern import wpws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_en,
    input  logic             feed_en,
    input  logic [SYM_W-1:0] symbol,
    input  logic             last,
    output logic             restart,
    output pattern_view_t    view
);

    logic [SYM_W-1:0] pattern_reg [PATTERN_MAX];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             closed_reg;
    logic             closed_next;
    logic [LEN_W-1:0] base_len;
    logic             room;

    // A symbol after a closed pattern starts a fresh one
    assign restart  = load_en && closed_reg;
    assign base_len = closed_reg ? '0 : len_reg;
    assign room     = base_len < LEN_W'(PATTERN_MAX);

    always_comb
    begin
        len_next    = len_reg;
        closed_next = closed_reg;
        if (load_en)
        begin
            len_next    = room ? base_len + LEN_W'(1) : base_len;
            closed_next = last;
        end
        else if (feed_en)
        begin
            closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            closed_reg <= 1'b1;
        end
        else
        begin
            len_reg    <= len_next;
            closed_reg <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && room)
        begin
            pattern_reg[base_len[IDX_W-1:0]] <= symbol;
        end
    end

    always_comb
    begin
        view.len = len_reg;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            view.syms[k] = pattern_reg[k];
            view.opt[k]  = (pattern_reg[k] == SYM_ZERO_OR_ONE);
            view.wild[k] = (pattern_reg[k] == SYM_ZERO_OR_ONE)
                        || (pattern_reg[k] == SYM_ANY_ONE);
        end
    end

endmodule

// ===== rtl/wpws_step.sv =====
module wpws_step import wpws_pkg::*;
(
    input  pattern_view_t       view,
    input  step_in_t            step,
    input  logic [THREAD_W-1:0] active,
    output logic [THREAD_W-1:0] active_next,
    output logic                hit
);

    logic [PATTERN_MAX-1:0] in_len;
    logic [PATTERN_MAX-1:0] opt;
    logic [THREAD_W-1:0]    seeded;
    logic [THREAD_W-1:0]    closed1;
    logic [THREAD_W-1:0]    advanced;

    // Close a thread set over runs of optional symbols: the carry of
    // opt + (active & opt) ripples through each run and lands past its end.
    function automatic logic [THREAD_W-1:0] close_opt(
        input logic [THREAD_W-1:0]    a,
        input logic [PATTERN_MAX-1:0] o
    );
        logic [THREAD_W-1:0] ext;
        logic [THREAD_W-1:0] sum;
        ext = {1'b0, o};
        sum = ext + {1'b0, a[PATTERN_MAX-1:0] & o};
        return a | (sum ^ ext);
    endfunction

    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            in_len[k] = LEN_W'(k) < view.len;
        end
    end

    assign opt     = view.opt & in_len;
    assign seeded  = active | {{(THREAD_W-1){1'b0}}, step.start};
    assign closed1 = close_opt(seeded, opt);

    always_comb
    begin
        advanced[0] = 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            advanced[k+1] = closed1[k] && in_len[k]
                         && (view.wild[k] || (view.syms[k] == step.symbol));
        end
    end

    assign active_next = close_opt(advanced, opt);
    assign hit         = closed1[view.len] || active_next[view.len];

endmodule

// ===== rtl/wildcard_pattern_window_search.sv =====
// Wildcard pattern search. Items with opcode 0 load a pattern of up to
// PATTERN_MAX symbols ('.' matches any byte, '-' matches zero or one byte,
// anything else matches itself); the first one after a finished pattern
// starts a new pattern and drops any sequence in progress. Items with
// opcode 1 stream sequence bytes; an attempt starts at each of the first
// search_window positions, and the byte marked last yields one result whose
// found bit tells whether any attempt covered the whole pattern. The block
// takes one item per clock unless stalled; the thread update, a 33-bit set
// closed over '-' by two carry chains, sits between the input register
// and the result register. Input stalls only while a result is held and
// the output side is not ready.
module wildcard_pattern_window_search import wpws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    wpws_in_if.sink            item,
    wpws_out_if.source         result,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    logic                s1_valid_reg;
    logic                s1_opcode_reg;
    logic [SYM_W-1:0]    s1_symbol_reg;
    logic                s1_last_reg;
    logic [COUNT_W-1:0]  window_reg;
    logic [THREAD_W-1:0] threads_reg;
    logic [THREAD_W-1:0] threads_next;
    logic [COUNT_W-1:0]  pos_reg;
    logic [COUNT_W-1:0]  pos_next;
    logic                found_reg;
    logic                found_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_found_reg;

    logic                emits;
    logic                advance;
    logic                load_en;
    logic                feed_en;
    logic                restart;
    logic                hit;
    logic [THREAD_W-1:0] stepped;
    pattern_view_t       view;
    step_in_t            step;

    assign emits   = s1_valid_reg && (s1_opcode_reg == OP_FEED) && s1_last_reg;
    assign advance = s1_valid_reg && (!emits || !out_valid_reg || result.ready);
    assign load_en = advance && (s1_opcode_reg == OP_LOAD);
    assign feed_en = advance && (s1_opcode_reg == OP_FEED);

    assign item.ready   = !s1_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.found = out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_opcode_reg <= item.opcode;
            s1_symbol_reg <= item.symbol;
            s1_last_reg   <= item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    wpws_pattern u_pattern (
        .clk     (clk),
        .rst_n   (rst_n),
        .load_en (load_en),
        .feed_en (feed_en),
        .symbol  (s1_symbol_reg),
        .last    (s1_last_reg),
        .restart (restart),
        .view    (view)
    );

    assign step.start  = pos_reg < window_reg;
    assign step.symbol = s1_symbol_reg;

    wpws_step u_step (
        .view        (view),
        .step        (step),
        .active      (threads_reg),
        .active_next (stepped),
        .hit         (hit)
    );

    always_comb
    begin
        threads_next   = threads_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (restart)
        begin
            threads_next = '0;
            pos_next     = '0;
            found_next   = 1'b0;
        end
        else if (feed_en)
        begin
            threads_next = stepped;
            pos_next     = (pos_reg == COUNT_MAX) ? pos_reg : pos_reg + COUNT_W'(1);
            found_next   = found_reg || hit;
            if (s1_last_reg)
            begin
                // report, then drop the sequence but keep the pattern
                out_valid_next = 1'b1;
                threads_next   = '0;
                pos_next       = '0;
                found_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threads_reg   <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            threads_reg   <= threads_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_en && s1_last_reg)
        begin
            out_found_reg <= found_reg || hit;
        end
    end

endmodule
